// ===== hdl/sorted_sparse_array_store_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the sorted sparse array store
// Shorthand for concurrent checks clocked on clk, with and without reset gating.
// ----------------------------------------------------------------------------
`ifndef SORTED_SPARSE_ARRAY_STORE_TOP_ASSERT_SVH
`define SORTED_SPARSE_ARRAY_STORE_TOP_ASSERT_SVH

// Check gated off while reset is asserted
`define SSAS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that holds on every edge, reset included
`define SSAS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/ssas_pkg.sv =====
// ----------------------------------------------------------------------------
// ssas_pkg
// Constants, op codes and sequencer states of the sorted sparse array store.
// ----------------------------------------------------------------------------
package ssas_pkg;

    // Array geometry
    localparam int ENTRIES = 32;
    localparam int ADDR_W  = $clog2(ENTRIES);
    localparam int IDX_W   = 5;
    localparam int LINK_W  = 6;
    localparam int VAL_W   = 32;

    // Link code for "no successor" / empty head
    localparam logic [LINK_W-1:0] LINK_NONE = '1;
    // -1.0 in Q16.16
    localparam logic [VAL_W-1:0]  MINUS_ONE = 32'hFFFF_0000;

    // Request op codes
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_LIST  = 2'd2;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_WALK_RD,
        ST_WALK_CHK,
        ST_LINK2,
        ST_VAL,
        ST_VAL_OUT,
        ST_EMPTY,
        ST_LST_RD,
        ST_LST_OUT
    } state_t;

    // True when a link names a real slot
    function automatic logic is_slot(input logic [LINK_W-1:0] p);
        is_slot = (p < LINK_W'(ENTRIES));
    endfunction

endpackage

// ===== hdl/sorted_sparse_array_store_top.sv =====
// ----------------------------------------------------------------------------
// sorted_sparse_array_store_top
// Sparse array whose touched slots form an ascending linked list in memory.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid/req_stall): op, index, wr_value. op 0 writes
//   wr_value to a slot, op 1 reads a slot, op 2 lists every touched slot in
//   ascending order. Write and read first link the slot into the list.
//   Result channel (res_valid/res_stall): out_index, out_value, last,
//   empty_res. A write gives no beat, a read one beat, a list one beat per
//   linked slot (last on the final one), or one empty_res beat.
//   One request is handled at a time; req_stall is high while it runs.
//   A write or read goes from START to VAL, the read then to VAL_OUT; a list
//   alternates LST_RD and LST_OUT per slot emitted. A slot above the head
//   first walks the next links from the head, and a slot not yet linked is
//   then spliced in (at most ENTRIES reads per walk).
//   Results sit in an output register; a stalled receiver holds the beat and
//   the sequencer waits before producing the next one.
//   Reset: asynchronous, clears the head and the per-entry valid bits, so all
//   slots read as -1.0 with no links at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sorted_sparse_array_store_top
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_stall,
    input  logic [1:0]                        op,
    input  logic [ssas_pkg::IDX_W-1:0]        index,
    input  logic signed [ssas_pkg::VAL_W-1:0] wr_value,
    output logic                              res_valid,
    input  logic                              res_stall,
    output logic [ssas_pkg::IDX_W-1:0]        out_index,
    output logic signed [ssas_pkg::VAL_W-1:0] out_value,
    output logic                              last,
    output logic                              empty_res
);

    localparam int AW = ssas_pkg::ADDR_W;
    localparam int LW = ssas_pkg::LINK_W;
    localparam int VW = ssas_pkg::VAL_W;
    localparam int IW = ssas_pkg::IDX_W;
    localparam int NE = ssas_pkg::ENTRIES;

    // Sequencer and request registers
    ssas_pkg::state_t state_reg, state_next;
    logic [1:0]       op_reg, op_next;
    logic [IW-1:0]    idx_reg, idx_next;
    logic [VW-1:0]    val_reg, val_next;
    logic [LW-1:0]    head_reg, head_next;
    logic [LW-1:0]    cur_reg, cur_next;
    logic             oor_reg, oor_next;

    // Output register
    logic             res_valid_reg, res_valid_next;
    logic [IW-1:0]    res_index_reg, res_index_next;
    logic [VW-1:0]    res_value_reg, res_value_next;
    logic             res_last_reg, res_last_next;
    logic             res_empty_reg, res_empty_next;

    // Memories and their valid bits
    logic [LW-1:0]    link_mem [NE];
    logic [VW-1:0]    val_mem  [NE];
    logic [NE-1:0]    link_vld_reg;
    logic [NE-1:0]    val_vld_reg;
    logic [LW-1:0]    link_rd_reg;
    logic             link_rv_reg;
    logic [VW-1:0]    val_rd_reg;
    logic             val_rv_reg;

    // Memory port controls
    logic             link_we, link_re, val_we, val_re;
    logic [AW-1:0]    link_waddr, link_raddr, val_addr;
    logic [LW-1:0]    link_wdata;

    // Derived values
    logic [LW-1:0]    s_link;
    logic [LW-1:0]    nx;
    logic [VW-1:0]    rd_value;
    logic             out_free;
    logic             s_ok;

    // State flags for the checks
    logic             walk_chk, list_out, in_walk, in_list;
    logic             head_ok, cur_ok, nx_slot;

    assign s_link   = {1'b0, idx_reg};
    assign s_ok     = ssas_pkg::is_slot(s_link);
    assign nx       = link_rv_reg ? link_rd_reg : ssas_pkg::LINK_NONE;
    assign rd_value = val_rv_reg ? val_rd_reg : ssas_pkg::MINUS_ONE;
    assign out_free = !res_valid_reg || !res_stall;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ssas_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ssas_pkg::ST_START;
                end
            end
            ssas_pkg::ST_START:
            begin
                if (op_reg == ssas_pkg::OP_WRITE || op_reg == ssas_pkg::OP_READ)
                begin
                    if (!s_ok)
                    begin
                        state_next = (op_reg == ssas_pkg::OP_READ) ?
                                     ssas_pkg::ST_VAL_OUT : ssas_pkg::ST_IDLE;
                    end
                    else if (!ssas_pkg::is_slot(head_reg) || s_link <= head_reg)
                    begin
                        state_next = ssas_pkg::ST_VAL;
                    end
                    else
                    begin
                        state_next = ssas_pkg::ST_WALK_RD;
                    end
                end
                else if (op_reg == ssas_pkg::OP_LIST)
                begin
                    state_next = ssas_pkg::is_slot(head_reg) ?
                                 ssas_pkg::ST_LST_RD : ssas_pkg::ST_EMPTY;
                end
                else
                begin
                    state_next = ssas_pkg::ST_IDLE;
                end
            end
            ssas_pkg::ST_WALK_RD:
            begin
                state_next = ssas_pkg::ST_WALK_CHK;
            end
            ssas_pkg::ST_WALK_CHK:
            begin
                if (ssas_pkg::is_slot(nx) && nx < s_link)
                begin
                    state_next = ssas_pkg::ST_WALK_RD;
                end
                else if (nx == s_link)
                begin
                    state_next = ssas_pkg::ST_VAL;
                end
                else
                begin
                    state_next = ssas_pkg::ST_LINK2;
                end
            end
            ssas_pkg::ST_LINK2:
            begin
                state_next = ssas_pkg::ST_VAL;
            end
            ssas_pkg::ST_VAL:
            begin
                state_next = (op_reg == ssas_pkg::OP_READ) ?
                             ssas_pkg::ST_VAL_OUT : ssas_pkg::ST_IDLE;
            end
            ssas_pkg::ST_VAL_OUT,
            ssas_pkg::ST_EMPTY:
            begin
                if (out_free)
                begin
                    state_next = ssas_pkg::ST_IDLE;
                end
            end
            ssas_pkg::ST_LST_RD:
            begin
                state_next = ssas_pkg::ST_LST_OUT;
            end
            ssas_pkg::ST_LST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ssas_pkg::is_slot(nx) ?
                                 ssas_pkg::ST_LST_RD : ssas_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ssas_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath, memory controls and result beats
    always_comb
    begin
        op_next        = op_reg;
        idx_next       = idx_reg;
        val_next       = val_reg;
        head_next      = head_reg;
        cur_next       = cur_reg;
        oor_next       = oor_reg;
        res_valid_next = res_valid_reg && res_stall;
        res_index_next = res_index_reg;
        res_value_next = res_value_reg;
        res_last_next  = res_last_reg;
        res_empty_next = res_empty_reg;
        link_we        = 1'b0;
        link_re        = 1'b0;
        val_we         = 1'b0;
        val_re         = 1'b0;
        link_waddr     = s_link[AW-1:0];
        link_wdata     = ssas_pkg::LINK_NONE;
        link_raddr     = cur_reg[AW-1:0];
        val_addr       = s_link[AW-1:0];
        req_stall      = (state_reg != ssas_pkg::ST_IDLE);

        unique case (state_reg)
            ssas_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    op_next  = op;
                    idx_next = index;
                    val_next = wr_value;
                end
            end
            ssas_pkg::ST_START:
            begin
                oor_next = !s_ok;
                cur_next = head_reg;
                if ((op_reg == ssas_pkg::OP_WRITE || op_reg == ssas_pkg::OP_READ) && s_ok)
                begin
                    // empty list: slot becomes the only entry
                    if (!ssas_pkg::is_slot(head_reg))
                    begin
                        head_next  = s_link;
                        link_we    = 1'b1;
                        link_wdata = ssas_pkg::LINK_NONE;
                    end
                    // below the head: slot becomes the new head
                    else if (s_link < head_reg)
                    begin
                        head_next  = s_link;
                        link_we    = 1'b1;
                        link_wdata = head_reg;
                    end
                end
            end
            ssas_pkg::ST_WALK_RD:
            begin
                link_re = 1'b1;
            end
            ssas_pkg::ST_WALK_CHK:
            begin
                if (ssas_pkg::is_slot(nx) && nx < s_link)
                begin
                    cur_next = nx;
                end
                else if (nx != s_link)
                begin
                    // new slot takes over the successor of cur
                    link_we    = 1'b1;
                    link_wdata = nx;
                end
            end
            ssas_pkg::ST_LINK2:
            begin
                link_we    = 1'b1;
                link_waddr = cur_reg[AW-1:0];
                link_wdata = s_link;
            end
            ssas_pkg::ST_VAL:
            begin
                val_we = (op_reg == ssas_pkg::OP_WRITE);
                val_re = (op_reg == ssas_pkg::OP_READ);
            end
            ssas_pkg::ST_VAL_OUT:
            begin
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    res_index_next = idx_reg;
                    res_value_next = oor_reg ? ssas_pkg::MINUS_ONE : rd_value;
                    res_last_next  = 1'b1;
                    res_empty_next = 1'b0;
                end
            end
            ssas_pkg::ST_EMPTY:
            begin
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    res_index_next = '0;
                    res_value_next = '0;
                    res_last_next  = 1'b1;
                    res_empty_next = 1'b1;
                end
            end
            ssas_pkg::ST_LST_RD:
            begin
                link_re  = 1'b1;
                val_re   = 1'b1;
                val_addr = cur_reg[AW-1:0];
            end
            ssas_pkg::ST_LST_OUT:
            begin
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    res_index_next = cur_reg[IW-1:0];
                    res_value_next = rd_value;
                    res_last_next  = !ssas_pkg::is_slot(nx);
                    res_empty_next = 1'b0;
                    cur_next       = nx;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ssas_pkg::ST_IDLE;
            head_reg      <= ssas_pkg::LINK_NONE;
            res_valid_reg <= 1'b0;
            link_vld_reg  <= '0;
            val_vld_reg   <= '0;
            link_rv_reg   <= 1'b0;
            val_rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            res_valid_reg <= res_valid_next;
            if (link_we)
            begin
                link_vld_reg[link_waddr] <= 1'b1;
            end
            if (val_we)
            begin
                val_vld_reg[val_addr] <= 1'b1;
            end
            if (link_re)
            begin
                link_rv_reg <= link_vld_reg[link_raddr];
            end
            if (val_re)
            begin
                val_rv_reg <= val_vld_reg[val_addr];
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        idx_reg       <= idx_next;
        val_reg       <= val_next;
        cur_reg       <= cur_next;
        oor_reg       <= oor_next;
        res_index_reg <= res_index_next;
        res_value_reg <= res_value_next;
        res_last_reg  <= res_last_next;
        res_empty_reg <= res_empty_next;
    end

    // Next-link memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        if (link_re)
        begin
            link_rd_reg <= link_mem[link_raddr];
        end
    end

    // Slot value memory, single port with registered read
    always_ff @(posedge clk)
    begin
        if (val_we)
        begin
            val_mem[val_addr] <= val_reg;
        end
        if (val_re)
        begin
            val_rd_reg <= val_mem[val_addr];
        end
    end

    assign res_valid = res_valid_reg;
    assign out_index = res_index_reg;
    assign out_value = res_value_reg;
    assign last      = res_last_reg;
    assign empty_res = res_empty_reg;

    // Flags used by the checks
    assign walk_chk = (state_reg == ssas_pkg::ST_WALK_CHK);
    assign list_out = (state_reg == ssas_pkg::ST_LST_OUT);
    assign in_walk  = walk_chk || (state_reg == ssas_pkg::ST_WALK_RD);
    assign in_list  = list_out || (state_reg == ssas_pkg::ST_LST_RD);
    assign head_ok  = ssas_pkg::is_slot(head_reg) || (head_reg == ssas_pkg::LINK_NONE);
    assign cur_ok   = ssas_pkg::is_slot(cur_reg);
    assign nx_slot  = ssas_pkg::is_slot(nx);

    // Assertions
    `include "sorted_sparse_array_store_top_assert.svh"

    `SSAS_ASSERT_ALWAYS(a_head_range, (!rst_n || head_ok), "head is neither none nor a slot")
    `SSAS_ASSERT(a_cur_slot, ((in_walk || in_list) |-> cur_ok), "walk cursor left the array")
    `SSAS_ASSERT(a_walk_below, (walk_chk |-> cur_reg < s_link), "walk passed the new slot")
    `SSAS_ASSERT(a_list_sorted, ((list_out && nx_slot) |-> nx > cur_reg), "list out of order")

endmodule

// ===== bench/sorted_sparse_array_store_top_tb.sv =====
// ----------------------------------------------------------------------------
// sorted_sparse_array_store_top_tb
// Drives write, read and list requests into the sorted sparse array store and
// checks every result beat against a shadow copy of the linked list and the
// slot values. Runs through phases of sender idling, receiver stalling and
// one long receiver hold-off that backs the block up.
// ----------------------------------------------------------------------------
module sorted_sparse_array_store_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int                IDX_W          = ssas_pkg::IDX_W;
    localparam int                VAL_W          = ssas_pkg::VAL_W;
    localparam int                LINK_W         = ssas_pkg::LINK_W;
    localparam int                ENTRIES        = ssas_pkg::ENTRIES;
    localparam logic [LINK_W-1:0] LINK_NONE      = ssas_pkg::LINK_NONE;
    localparam logic [VAL_W-1:0]  MINUS_ONE      = ssas_pkg::MINUS_ONE;
    localparam logic [1:0]        OP_UNUSED      = 2'd3;
    localparam int                HOLD_CYCLES    = 300;
    localparam int                WATCHDOG_LIMIT = 3000;
    localparam int                SETTLE_CYCLES  = 100;
    localparam int                MAX_PRINTS     = 50;

    // Traffic phases
    typedef enum logic [2:0] {
        PH_FREE,
        PH_SEND_IDLE,
        PH_RECV_STALL,
        PH_BOTH,
        PH_PRESSURE
    } phase_t;

    typedef struct packed {
        logic [1:0]       op;
        logic [IDX_W-1:0] idx;
        logic [VAL_W-1:0] val;
    } request_t;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [VAL_W-1:0] val;
        logic             last;
        logic             empty;
    } beat_t;

    // DUT signals
    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     req_valid = 1'b0;
    logic                     req_stall;
    logic [1:0]               op        = '0;
    logic [IDX_W-1:0]         index     = '0;
    logic signed [VAL_W-1:0]  wr_value  = '0;
    logic                     res_valid;
    logic                     res_stall = 1'b0;
    logic [IDX_W-1:0]         out_index;
    logic signed [VAL_W-1:0]  out_value;
    logic                     last;
    logic                     empty_res;

    // Bench state
    phase_t           phase = PH_FREE;
    request_t         pending_reqs[$];
    beat_t            beats_due[$];
    logic [ENTRIES-1:0] touched_gen = '0;
    int               mismatches = 0;
    int               idle_cycles = 0;
    int               hold_left = 0;
    bit               hold_done = 1'b0;
    bit               run_done = 1'b0;

    // Shadow copy of the store
    logic [LINK_W-1:0] shadow_next[ENTRIES];
    logic [VAL_W-1:0]  shadow_value[ENTRIES];
    logic [LINK_W-1:0] shadow_head;

    always #4 clk = ~clk;

    sorted_sparse_array_store_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .op        (op),
        .index     (index),
        .wr_value  (wr_value),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .out_index (out_index),
        .out_value (out_value),
        .last      (last),
        .empty_res (empty_res)
    );

    initial
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            shadow_next[i]  = LINK_NONE;
            shadow_value[i] = MINUS_ONE;
        end
        shadow_head = LINK_NONE;
    end

    // Insert a slot into the ascending list, walking from the head
    function automatic void link_slot(input logic [IDX_W-1:0] s);
        logic [LINK_W-1:0] cur;
        logic [LINK_W-1:0] nx;
        int                steps;
        cur   = shadow_head;
        steps = 0;
        if (cur >= LINK_W'(ENTRIES))
        begin
            shadow_head    = LINK_W'(s);
            shadow_next[s] = LINK_NONE;
            return;
        end
        if (LINK_W'(s) == cur)
            return;
        // new slot goes in front of the head
        if (LINK_W'(s) < cur)
        begin
            shadow_next[s] = cur;
            shadow_head    = LINK_W'(s);
            return;
        end
        while (steps < ENTRIES)
        begin
            nx = shadow_next[cur[IDX_W-1:0]];
            if (nx >= LINK_W'(ENTRIES) || nx > LINK_W'(s))
                break;
            cur = nx;
            steps++;
        end
        if (cur == LINK_W'(s))
            return;
        shadow_next[s] = shadow_next[cur[IDX_W-1:0]];
        shadow_next[cur[IDX_W-1:0]] = LINK_W'(s);
    endfunction

    // Apply one accepted request and queue the beats it must produce
    function automatic void predict_request(input request_t rq);
        logic [LINK_W-1:0] cur;
        logic [LINK_W-1:0] nxt;
        int                n;
        beat_t             b;
        case (rq.op)
            ssas_pkg::OP_WRITE:
            begin
                link_slot(rq.idx);
                shadow_value[rq.idx] = rq.val;
            end
            ssas_pkg::OP_READ:
            begin
                link_slot(rq.idx);
                b = '{idx: rq.idx, val: shadow_value[rq.idx], last: 1'b1, empty: 1'b0};
                beats_due.push_back(b);
            end
            ssas_pkg::OP_LIST:
            begin
                cur = shadow_head;
                if (cur >= LINK_W'(ENTRIES))
                begin
                    b = '{idx: '0, val: '0, last: 1'b1, empty: 1'b1};
                    beats_due.push_back(b);
                end
                else
                begin
                    n = 0;
                    while (cur < LINK_W'(ENTRIES) && n < ENTRIES)
                    begin
                        nxt = shadow_next[cur[IDX_W-1:0]];
                        b.idx   = cur[IDX_W-1:0];
                        b.val   = shadow_value[cur[IDX_W-1:0]];
                        b.last  = (nxt >= LINK_W'(ENTRIES)) || (n + 1 == ENTRIES);
                        b.empty = 1'b0;
                        beats_due.push_back(b);
                        n++;
                        cur = nxt;
                    end
                end
            end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < MAX_PRINTS)
            $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
        mismatches++;
    endtask

    // Stimulus helpers
    task automatic queue_req(input logic [1:0] o, input logic [IDX_W-1:0] i,
                             input logic [VAL_W-1:0] v);
        request_t rq;
        rq = '{op: o, idx: i, val: v};
        if (o == ssas_pkg::OP_WRITE || o == ssas_pkg::OP_READ)
            touched_gen[i] = 1'b1;
        pending_reqs.push_back(rq);
    endtask

    // Favor slots not yet linked so insertions spread over the run
    function automatic logic [IDX_W-1:0] pick_index();
        logic [IDX_W-1:0] i;
        i = IDX_W'($urandom_range(0, ENTRIES - 1));
        if (touched_gen != '1 && $urandom_range(0, 3) == 0)
            while (touched_gen[i])
                i = IDX_W'($urandom_range(0, ENTRIES - 1));
        return i;
    endfunction

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return '0;
            3:       return MINUS_ONE;
            default: return $urandom;
        endcase
    endfunction

    // Ignored op codes do not count toward n
    task automatic queue_random(input int n);
        int r;
        int done_cnt;
        done_cnt = 0;
        while (done_cnt < n)
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
                queue_req(ssas_pkg::OP_WRITE, pick_index(), pick_value());
            else if (r < 80)
                queue_req(ssas_pkg::OP_READ, pick_index(), pick_value());
            else if (r < 92)
                queue_req(ssas_pkg::OP_LIST, IDX_W'($urandom), $urandom);
            else
                queue_req(OP_UNUSED, IDX_W'($urandom), $urandom);
            if (r < 92)
                done_cnt++;
        end
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || beats_due.size() != 0)
            @(posedge clk);
    endtask

    function automatic int send_idle_pct();
        case (phase)
            PH_SEND_IDLE: return 57;
            PH_BOTH:      return 24;
            default:      return 0;
        endcase
    endfunction

    function automatic int recv_stall_pct();
        case (phase)
            PH_RECV_STALL: return 57;
            PH_BOTH:       return 24;
            default:       return 0;
        endcase
    endfunction

    // Request driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && !req_stall)
                predict_request('{op: op, idx: index, val: wr_value});
            if (!req_valid || !req_stall)
            begin
                if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct())
                begin
                    request_t rq;
                    rq = pending_reqs.pop_front();
                    req_valid <= 1'b1;
                    op        <= rq.op;
                    index     <= rq.idx;
                    wr_value  <= rq.val;
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, counted in cycles
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (phase == PH_PRESSURE && !hold_done)
            begin
                hold_left <= HOLD_CYCLES;
                hold_done <= 1'b1;
            end
            else if (hold_left > 0)
                hold_left <= hold_left - 1;
        end
    end

    // Result monitor and receiver stall
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_valid && !res_stall)
            begin
                if (beats_due.size() == 0)
                    report_mismatch("unexpected beat index", 32'(out_index), '0);
                else
                begin
                    beat_t b;
                    b = beats_due.pop_front();
                    if (out_index !== b.idx)
                        report_mismatch("out_index", 32'(out_index), 32'(b.idx));
                    if (out_value !== b.val)
                        report_mismatch("out_value", out_value, b.val);
                    if (last !== b.last)
                        report_mismatch("last", 32'(last), 32'(b.last));
                    if (empty_res !== b.empty)
                        report_mismatch("empty_res", 32'(empty_res), 32'(b.empty));
                end
            end
            // hold off while the sender keeps pushing
            if (hold_left > 0)
                res_stall <= 1'b1;
            else
                res_stall <= ($urandom_range(0, 99) < recv_stall_pct());
        end
    end

    // Watchdog on cycles with no beat moving on either channel
    always @(posedge clk)
    begin
        if (rst_n && !run_done)
        begin
            if ((req_valid && !req_stall) || (res_valid && !res_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Sequence of phases
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty list, insert into empty, tail, before head, middle
        queue_req(ssas_pkg::OP_LIST,  5'd9,  32'h1234_5678);
        queue_req(ssas_pkg::OP_READ,  5'd5,  32'hDEAD_BEEF);
        queue_req(ssas_pkg::OP_WRITE, 5'd31, 32'h7FFF_FFFF);
        queue_req(ssas_pkg::OP_WRITE, 5'd0,  32'h8000_0000);
        queue_req(ssas_pkg::OP_READ,  5'd0,  '0);
        queue_req(ssas_pkg::OP_WRITE, 5'd10, '0);
        queue_req(ssas_pkg::OP_WRITE, 5'd3,  32'hFFFF_FFFF);
        queue_req(OP_UNUSED,          5'd7,  32'hFFFF_FFFF);
        queue_req(ssas_pkg::OP_LIST,  5'd31, '0);
        // rewrite existing head and tail
        queue_req(ssas_pkg::OP_WRITE, 5'd0,  32'h0001_0000);
        queue_req(ssas_pkg::OP_WRITE, 5'd31, 32'h0000_8000);
        queue_req(ssas_pkg::OP_READ,  5'd20, '0);
        queue_req(ssas_pkg::OP_READ,  5'd31, '0);
        queue_req(ssas_pkg::OP_WRITE, 5'd30, 32'hAAAA_AAAA);
        queue_req(ssas_pkg::OP_WRITE, 5'd1,  32'h5555_5555);
        queue_req(ssas_pkg::OP_WRITE, 5'd16, 32'h7FFF_0000);
        queue_req(ssas_pkg::OP_LIST,  5'd0,  '0);
        queue_req(OP_UNUSED,          5'd31, '0);
        queue_req(ssas_pkg::OP_READ,  5'd3,  '0);
        queue_req(ssas_pkg::OP_WRITE, 5'd2,  MINUS_ONE);
        queue_req(ssas_pkg::OP_LIST,  5'd17, 32'hFFFF_FFFF);
        wait_drained();

        phase = PH_SEND_IDLE;
        queue_random(37);
        wait_drained();

        phase = PH_RECV_STALL;
        queue_random(37);
        wait_drained();

        phase = PH_BOTH;
        queue_random(37);
        wait_drained();

        phase = PH_PRESSURE;
        queue_random(36);
        wait_drained();

        phase = PH_FREE;
        queue_random(37);
        wait_drained();

        // let a trailing write finish and catch stray beats
        run_done = 1'b1;
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && beats_due.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
